// File: src/voxel_face_cull_scanner_defines.svh
// Assertion macros for the voxel face scanner.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef VOXEL_FACE_CULL_SCANNER_DEFINES_SVH
`define VOXEL_FACE_CULL_SCANNER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define VFC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/vfc_pkg.sv
// Shared types and constants for the voxel face scanner.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package vfc_pkg;

	localparam int DIR_W  = 3;

	typedef logic [DIR_W-1:0] sel_t;

	// Face directions, in emission order; SEL_CENTER reads the scanned cell.
	localparam sel_t DIR_PZ     = 3'd0;
	localparam sel_t DIR_NZ     = 3'd1;
	localparam sel_t DIR_NX     = 3'd2;
	localparam sel_t DIR_PX     = 3'd3;
	localparam sel_t DIR_PY     = 3'd4;
	localparam sel_t DIR_NY     = 3'd5;
	localparam sel_t SEL_CENTER = 3'd6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCAN  = 1'b1;

	typedef struct packed {
		logic in_ready;
		logic clear_wr;
		logic cell_wr;
		logic rd_en;
		sel_t rd_sel;
		logic emit;
		logic advance;
	} vfc_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
		logic emit_last;
	} vfc_stat_t;

endpackage

// File: src/vfc_chan_if.sv
// Valid/ready channel interfaces for the voxel face scanner.
// Depends on nothing; used by the top level ports.
`timescale 1ns / 1ps

interface vfc_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [3:0] cell_x;
	logic [3:0] cell_y;
	logic [3:0] cell_z;
	logic [3:0] voxel_value;

	modport source (output valid, command, cell_x, cell_y, cell_z, voxel_value, input ready);
	modport sink (input valid, command, cell_x, cell_y, cell_z, voxel_value, output ready);
endinterface

interface vfc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] face_x;
	logic [3:0] face_y;
	logic [3:0] face_z;
	logic [2:0] face_dir;
	logic [3:0] face_type;
	logic       face_valid;
	logic       last_of_cell;
	logic       scan_done;

	modport source (output valid, face_x, face_y, face_z, face_dir, face_type, face_valid,
		last_of_cell, scan_done, input ready);
	modport sink (input valid, face_x, face_y, face_z, face_dir, face_type, face_valid,
		last_of_cell, scan_done, output ready);
endinterface

// File: src/vfc_ctrl.sv
// Controller state machine: clearing pass, item accept, neighbor reads, face emission.
// Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_ctrl
	import vfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_command,
	input  vfc_stat_t stat,
	output vfc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	sel_t   rd_cnt_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.cell_wr  = in_valid && (in_command == CMD_WRITE);
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rd_cnt_q;
			end
			ST_WAIT: begin
			end
			ST_EMIT: begin
				cmd.emit    = stat.out_free;
				cmd.advance = stat.out_free && stat.emit_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			rd_cnt_q <= DIR_PZ;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && (in_command == CMD_SCAN)) begin
						state_q  <= ST_READ;
						rd_cnt_q <= DIR_PZ;
					end
				end
				ST_READ: begin
					// issue the six neighbors, then the cell itself
					rd_cnt_q <= rd_cnt_q + sel_t'(1);
					if (rd_cnt_q == SEL_CENTER) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free && stat.emit_last) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/vfc_datapath.sv
// Datapath: voxel grid memory, scan counters, visibility mask and output register.
// Depends on vfc_pkg; driven by vfc_ctrl through command and status structs.
`timescale 1ns / 1ps

module vfc_datapath
	import vfc_pkg::*;
#(
	parameter int SIZE_X    = 16,
	parameter int SIZE_Y    = 16,
	parameter int SIZE_Z    = 16,
	parameter int TYPE_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  vfc_cmd_t    cmd,
	output vfc_stat_t   stat,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic [3:0]  cell_x,
	input  logic [3:0]  cell_y,
	input  logic [3:0]  cell_z,
	input  logic [3:0]  voxel_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  face_x,
	output logic [3:0]  face_y,
	output logic [3:0]  face_z,
	output logic [2:0]  face_dir,
	output logic [3:0]  face_type,
	output logic        face_valid,
	output logic        last_of_cell,
	output logic        scan_done
);

	localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(SIZE_X);
	localparam int YW    = $clog2(SIZE_Y);
	localparam int ZW    = $clog2(SIZE_Z);
	localparam int TW    = TYPE_BITS;

	typedef logic [TW-1:0] vox_t;

	function automatic logic [AW-1:0] addr_of(logic [XW-1:0] x, logic [YW-1:0] y,
		logic [ZW-1:0] z);
		return AW'((32'(x) * SIZE_Y + 32'(y)) * SIZE_Z + 32'(z));
	endfunction

	vox_t mem [CELLS];
	vox_t rdata_q;

	logic [AW-1:0] clr_q;
	logic [3:0]    air_q;
	logic [XW-1:0] scan_x_q;
	logic [YW-1:0] scan_y_q;
	logic [ZW-1:0] scan_z_q;
	logic          rd_v_s1;
	sel_t          rd_sel_s1;
	vox_t          cell_q;
	logic [5:0]    vis_q;

	// widened copies give the masked or zero-extended view in either direction
	logic [TW+3:0] air_ext;
	logic [TW+3:0] val_ext;
	logic [TW+3:0] cell_ext;
	logic [XW+3:0] wx_ext, sx_ext;
	logic [YW+3:0] wy_ext, sy_ext;
	logic [ZW+3:0] wz_ext, sz_ext;
	vox_t          air_t;

	logic          wr_in_range;
	logic          mem_we;
	logic [AW-1:0] waddr;
	vox_t          wdata;

	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [ZW-1:0] nz;
	logic [AW-1:0] raddr;
	logic [5:0]    bnd;
	logic          x_max, y_max, z_max;

	logic [5:0]    pend;
	logic [5:0]    low_hot;
	sel_t          low_idx;
	logic          emit_last;
	logic          out_free;

	assign air_ext  = (TW + 4)'(air_q);
	assign air_t    = air_ext[TW-1:0];
	assign val_ext  = (TW + 4)'(voxel_value);
	assign cell_ext = (TW + 4)'(cell_q);
	assign wx_ext   = (XW + 4)'(cell_x);
	assign wy_ext   = (YW + 4)'(cell_y);
	assign wz_ext   = (ZW + 4)'(cell_z);
	assign sx_ext   = (XW + 4)'(scan_x_q);
	assign sy_ext   = (YW + 4)'(scan_y_q);
	assign sz_ext   = (ZW + 4)'(scan_z_q);

	assign x_max = (scan_x_q == XW'(SIZE_X - 1));
	assign y_max = (scan_y_q == YW'(SIZE_Y - 1));
	assign z_max = (scan_z_q == ZW'(SIZE_Z - 1));

	// grid edge in each face direction: the face is visible regardless of memory
	assign bnd[DIR_PZ] = z_max;
	assign bnd[DIR_NZ] = (scan_z_q == '0);
	assign bnd[DIR_NX] = (scan_x_q == '0);
	assign bnd[DIR_PX] = x_max;
	assign bnd[DIR_PY] = y_max;
	assign bnd[DIR_NY] = (scan_y_q == '0);

	// write port: clearing pass or a write beat
	assign wr_in_range = (32'(cell_x) < SIZE_X) && (32'(cell_y) < SIZE_Y) &&
		(32'(cell_z) < SIZE_Z);
	assign mem_we = cmd.clear_wr || (cmd.cell_wr && wr_in_range);
	assign waddr  = cmd.clear_wr ? clr_q :
		addr_of(wx_ext[XW-1:0], wy_ext[YW-1:0], wz_ext[ZW-1:0]);
	assign wdata  = cmd.clear_wr ? '0 : val_ext[TW-1:0];

	// read port: neighbor coordinates, held on the cell at the grid edge
	always_comb begin
		nx = scan_x_q;
		ny = scan_y_q;
		nz = scan_z_q;
		unique case (cmd.rd_sel)
			DIR_PZ: if (!bnd[DIR_PZ]) nz = scan_z_q + ZW'(1);
			DIR_NZ: if (!bnd[DIR_NZ]) nz = scan_z_q - ZW'(1);
			DIR_NX: if (!bnd[DIR_NX]) nx = scan_x_q - XW'(1);
			DIR_PX: if (!bnd[DIR_PX]) nx = scan_x_q + XW'(1);
			DIR_PY: if (!bnd[DIR_PY]) ny = scan_y_q + YW'(1);
			DIR_NY: if (!bnd[DIR_NY]) ny = scan_y_q - YW'(1);
			default: begin
			end
		endcase
	end

	assign raddr = addr_of(nx, ny, nz);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[raddr];
	end

	// pending faces; an air cell shows none
	assign pend = (cell_q == air_t) ? 6'b0 : vis_q;

	always_comb begin
		low_idx = DIR_PZ;
		for (int d = 5; d >= 0; d--) begin
			if (pend[d]) low_idx = sel_t'(d);
		end
	end

	assign low_hot   = (pend == '0) ? 6'b0 : (6'b1 << low_idx);
	assign emit_last = ((pend & ~low_hot) == '0);
	assign out_free  = !out_valid || out_ready;

	assign stat.clear_done = (clr_q == AW'(CELLS - 1));
	assign stat.out_free   = out_free;
	assign stat.emit_last  = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			air_q     <= '0;
			scan_x_q  <= '0;
			scan_y_q  <= '0;
			scan_z_q  <= '0;
			rd_v_s1   <= 1'b0;
			rd_sel_s1 <= DIR_PZ;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear_wr && !stat.clear_done) clr_q <= clr_q + AW'(1);
			if (cfg_wr_en) air_q <= cfg_wr_data;
			rd_v_s1   <= cmd.rd_en;
			rd_sel_s1 <= cmd.rd_sel;

			// advance z innermost, then y, then x; wrap after the last cell
			if (cmd.advance) begin
				if (!z_max) begin
					scan_z_q <= scan_z_q + ZW'(1);
				end else begin
					scan_z_q <= '0;
					if (!y_max) begin
						scan_y_q <= scan_y_q + YW'(1);
					end else begin
						scan_y_q <= '0;
						scan_x_q <= x_max ? '0 : scan_x_q + XW'(1);
					end
				end
			end

			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// capture the registered read data under the staged valid and select; drop faces as they go out
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (rd_sel_s1 == SEL_CENTER) begin
				cell_q <= rdata_q;
			end else begin
				vis_q[rd_sel_s1] <= bnd[rd_sel_s1] || (rdata_q == air_t);
			end
		end else if (cmd.emit) begin
			vis_q <= vis_q & ~low_hot;
		end

		if (cmd.emit) begin
			face_x       <= sx_ext[3:0];
			face_y       <= sy_ext[3:0];
			face_z       <= sz_ext[3:0];
			face_dir     <= low_idx;
			face_type    <= cell_ext[3:0];
			face_valid   <= (pend != '0);
			last_of_cell <= emit_last;
			scan_done    <= emit_last && x_max && y_max && z_max;
		end
	end

endmodule

// File: src/voxel_face_cull_scanner.sv
// Top level of the voxel face scanner: joins controller and datapath to the channels.
// Depends on vfc_pkg, vfc_chan_if, vfc_ctrl, vfc_datapath and the assertion macros.
//
//  channel | role   | handshake         | payload
//  in_ch   | sink   | valid/ready       | command, cell_x/y/z, voxel_value
//  out_ch  | source | valid/ready       | face_x/y/z, face_dir, face_type, flags
//  cfg     | sink   | cfg_wr_en         | cfg_wr_data (air_code)
//
// A write beat is taken while idle. A scan beat first reads the grid (six neighbors
// and the cell through the single memory read port), then emits one result per cycle
// while the output is not stalled, 1 to 6 results per scan item.
// After reset a clearing pass writes zero to every grid cell (SIZE_X*SIZE_Y*SIZE_Z
// cells, 4096 by default); in_ch.ready stays low until it ends.
// A stalled output holds the emission phase; in_ch.ready is high only when idle.
`timescale 1ns / 1ps
`include "voxel_face_cull_scanner_defines.svh"

module voxel_face_cull_scanner
	import vfc_pkg::*;
#(
	parameter int SIZE_X    = 16,
	parameter int SIZE_Y    = 16,
	parameter int SIZE_Z    = 16,
	parameter int TYPE_BITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	vfc_in_if.sink     in_ch,
	vfc_out_if.source  out_ch
);

	vfc_cmd_t  cmd;
	vfc_stat_t stat;

	assign in_ch.ready = cmd.in_ready;

	vfc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.stat       (stat),
		.cmd        (cmd)
	);

	vfc_datapath #(
		.SIZE_X    (SIZE_X),
		.SIZE_Y    (SIZE_Y),
		.SIZE_Z    (SIZE_Z),
		.TYPE_BITS (TYPE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cell_x       (in_ch.cell_x),
		.cell_y       (in_ch.cell_y),
		.cell_z       (in_ch.cell_z),
		.voxel_value  (in_ch.voxel_value),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.face_x       (out_ch.face_x),
		.face_y       (out_ch.face_y),
		.face_z       (out_ch.face_z),
		.face_dir     (out_ch.face_dir),
		.face_type    (out_ch.face_type),
		.face_valid   (out_ch.face_valid),
		.last_of_cell (out_ch.last_of_cell),
		.scan_done    (out_ch.scan_done)
	);

	`VFC_ASSERT_SAME(a_no_accept_in_clear, cmd.clear_wr, !in_ch.ready, "beat accepted during clear")
	`VFC_ASSERT_SAME(a_noface_alone, out_ch.valid && !out_ch.face_valid, out_ch.last_of_cell, "faceless result not last")
	`VFC_ASSERT_SAME(a_done_is_last, out_ch.valid && out_ch.scan_done, out_ch.last_of_cell, "scan_done off last result")
	`VFC_ASSERT_NEXT(a_idle_after_cell, cmd.advance, in_ch.ready, "not idle after final result")

endmodule

// File: dv/voxel_face_cull_scanner_test.sv
// Self-checking testbench for voxel_face_cull_scanner: a directed table, then random mixed
// beats. Depends on vfc_pkg, vfc_chan_if and the block's RTL.
`timescale 1ns / 1ps

module voxel_face_cull_scanner_test;
	import vfc_pkg::*;

	localparam int GRID_N = 16;
	localparam logic [3:0] TYPE_MASK = 4'hF;

	typedef struct packed {
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		sel_t       dir;
		logic [3:0] kind;
		logic       visible;
		logic       last_of_cell;
		logic       scan_done;
	} face_beat_t;

	typedef struct {
		logic       cmd;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		logic [3:0] v;
		bit         typed;
		face_beat_t want;
	} stim_row_t;

	localparam face_beat_t NO_FACE = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [3:0] cfg_wr_data;

	vfc_in_if in_ch();
	vfc_out_if out_ch();

	voxel_face_cull_scanner i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the grid, the scan cursor and the air code.
	logic [3:0] shadow_grid [GRID_N][GRID_N][GRID_N];
	logic [3:0] shadow_air;
	int cur_x, cur_y, cur_z;

	face_beat_t cell_faces[$];
	face_beat_t pending_faces[$];
	int mismatches = 0;
	int burst_left = 0;
	bit steady = 0;

	// Starting at cell (0,0,0) with the grid cleared and air code 0.
	stim_row_t directed_rows [27] = '{
		'{CMD_SCAN,  0, 0,  0,  0, 1, '{0, 0, 0, DIR_PZ, 0, 0, 1, 0}},
		'{CMD_WRITE, 0, 0,  2, 15, 0, NO_FACE},
		'{CMD_WRITE, 0, 0,  3,  1, 0, NO_FACE},
		'{CMD_WRITE, 0, 1,  2, 15, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 1, '{0, 0, 1, DIR_PZ, 0, 0, 1, 0}},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_WRITE, 15, 15, 15, 15, 0, NO_FACE},
		'{CMD_WRITE, 15, 15, 14,  9, 0, NO_FACE},
		'{CMD_WRITE, 15, 0,  0,  8, 0, NO_FACE},
		'{CMD_WRITE, 0, 15,  0,  4, 0, NO_FACE},
		'{CMD_WRITE, 0, 0,  6,  3, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 1, '{0, 0, 4, DIR_PZ, 0, 0, 1, 0}},
		'{CMD_SCAN,  0, 0,  0,  0, 1, '{0, 0, 5, DIR_PZ, 0, 0, 1, 0}},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_WRITE, 0, 0,  7,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 1, '{0, 0, 7, DIR_PZ, 0, 0, 1, 0}},
		'{CMD_WRITE, 0, 0, 15, 12, 0, NO_FACE},
		'{CMD_WRITE, 0, 0, 14, 12, 0, NO_FACE},
		'{CMD_SCAN, 15, 15, 15, 15, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE},
		'{CMD_SCAN,  0, 0,  0,  0, 0, NO_FACE}
	};

	function automatic bit is_empty(logic [3:0] kind);
		return kind == (shadow_air & TYPE_MASK);
	endfunction

	// Fill cell_faces with the beats one item produces, and update the shadow state.
	function automatic void predict_faces(logic cmd, logic [3:0] wx, logic [3:0] wy,
			logic [3:0] wz, logic [3:0] wv);
		logic [3:0] kind;
		bit seen [6];
		face_beat_t fb;
		cell_faces.delete();
		if (cmd == CMD_WRITE) begin
			if (wx < GRID_N && wy < GRID_N && wz < GRID_N)
				shadow_grid[wx][wy][wz] = wv & TYPE_MASK;
			return;
		end
		kind = shadow_grid[cur_x][cur_y][cur_z];
		if (is_empty(kind)) begin
			foreach (seen[d])
				seen[d] = 0;
		end else begin
			seen[DIR_PZ] = cur_z == GRID_N - 1 || is_empty(shadow_grid[cur_x][cur_y][cur_z + 1]);
			seen[DIR_NZ] = cur_z == 0 || is_empty(shadow_grid[cur_x][cur_y][cur_z - 1]);
			seen[DIR_NX] = cur_x == 0 || is_empty(shadow_grid[cur_x - 1][cur_y][cur_z]);
			seen[DIR_PX] = cur_x == GRID_N - 1 || is_empty(shadow_grid[cur_x + 1][cur_y][cur_z]);
			seen[DIR_PY] = cur_y == GRID_N - 1 || is_empty(shadow_grid[cur_x][cur_y + 1][cur_z]);
			seen[DIR_NY] = cur_y == 0 || is_empty(shadow_grid[cur_x][cur_y - 1][cur_z]);
		end
		fb = '{x: 4'(cur_x), y: 4'(cur_y), z: 4'(cur_z), dir: DIR_PZ, kind: kind,
			visible: 1'b0, last_of_cell: 1'b0, scan_done: 1'b0};
		for (int d = 0; d < 6; d++) begin
			if (seen[d]) begin
				fb.dir = sel_t'(d);
				fb.visible = 1'b1;
				cell_faces.insert(cell_faces.size(), fb);
			end
		end
		if (cell_faces.size() == 0)
			cell_faces.insert(0, fb);
		cell_faces[cell_faces.size() - 1].last_of_cell = 1'b1;
		cell_faces[cell_faces.size() - 1].scan_done =
			cur_x == GRID_N - 1 && cur_y == GRID_N - 1 && cur_z == GRID_N - 1;
		// Advance z innermost, then y, then x; wrap after the last cell.
		if (cur_z + 1 < GRID_N) begin
			cur_z++;
		end else begin
			cur_z = 0;
			if (cur_y + 1 < GRID_N) begin
				cur_y++;
			end else begin
				cur_y = 0;
				cur_x = (cur_x + 1 < GRID_N) ? cur_x + 1 : 0;
			end
		end
	endfunction

	function automatic logic [3:0] nudge(logic [3:0] c, int lo, int hi);
		return 4'(int'(c) + lo + int'($urandom_range(0, hi - lo)));
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// Drive one input beat in bursts with random gaps, then queue its expected faces.
	task automatic send_beat(input logic cmd, input logic [3:0] x, input logic [3:0] y,
			input logic [3:0] z, input logic [3:0] v, input bit typed = 0,
			input face_beat_t want = '0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.cell_x <= x;
		in_ch.cell_y <= y;
		in_ch.cell_z <= z;
		in_ch.voxel_value <= v;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		predict_faces(cmd, x, y, z, v);
		if (typed)
			pending_faces.insert(pending_faces.size(), want);
		else
			foreach (cell_faces[i])
				pending_faces.insert(pending_faces.size(), cell_faces[i]);
	endtask

	// Write air_code once the block has drained.
	task automatic set_air(input logic [3:0] code);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_air = code;
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 4'd0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_WRITE;
		in_ch.cell_x = 4'd0;
		in_ch.cell_y = 4'd0;
		in_ch.cell_z = 4'd0;
		in_ch.voxel_value = 4'd0;
		foreach (shadow_grid[i, j, k])
			shadow_grid[i][j][k] = 4'd0;
		shadow_air = 4'd0;
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		set_air(4'd0);

		foreach (directed_rows[r])
			send_beat(directed_rows[r].cmd, directed_rows[r].x, directed_rows[r].y,
				directed_rows[r].z, directed_rows[r].v, directed_rows[r].typed,
				directed_rows[r].want);

		// Mixed beats: writes cluster around the scan cursor so neighbors matter.
		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: set_air(4'($urandom_range(1, 14)));
				1: set_air(4'hF);
				2: set_air(4'h0);
				default: set_air(4'($urandom));
			endcase
			steady = (seg == 2);
			repeat (113) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					send_beat(CMD_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
				else if (pick < 85)
					send_beat(CMD_WRITE, nudge(4'(cur_x), 0, 1), nudge(4'(cur_y), -1, 1),
						nudge(4'(cur_z), -1, 2), 4'($urandom));
				else
					send_beat(CMD_WRITE, 4'($urandom), 4'($urandom), 4'($urandom),
						4'($urandom));
			end
		end

		in_ch.valid <= 1'b0;
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Output side: stall on a random ready mask that is redrawn periodically; check each beat.
	initial begin
		face_beat_t want_face;
		logic [15:0] ready_mask;
		int unsigned rx_cycle;
		out_ch.ready = 1'b0;
		ready_mask = '1;
		rx_cycle = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_ch.valid && out_ch.ready) begin
					if (pending_faces.size() == 0) begin
						flag_mismatch("beat with nothing pending, face_dir", out_ch.face_dir, 0);
					end else begin
						want_face = pending_faces.pop_front();
						if (out_ch.face_x !== want_face.x)
							flag_mismatch("face_x", out_ch.face_x, want_face.x);
						if (out_ch.face_y !== want_face.y)
							flag_mismatch("face_y", out_ch.face_y, want_face.y);
						if (out_ch.face_z !== want_face.z)
							flag_mismatch("face_z", out_ch.face_z, want_face.z);
						if (out_ch.face_dir !== want_face.dir)
							flag_mismatch("face_dir", out_ch.face_dir, want_face.dir);
						if (out_ch.face_type !== want_face.kind)
							flag_mismatch("face_type", out_ch.face_type, want_face.kind);
						if (out_ch.face_valid !== want_face.visible)
							flag_mismatch("face_valid", out_ch.face_valid, want_face.visible);
						if (out_ch.last_of_cell !== want_face.last_of_cell)
							flag_mismatch("last_of_cell", out_ch.last_of_cell,
								want_face.last_of_cell);
						if (out_ch.scan_done !== want_face.scan_done)
							flag_mismatch("scan_done", out_ch.scan_done, want_face.scan_done);
					end
				end
				if (rx_cycle[5:0] == 6'd0) begin
					case ($urandom_range(0, 3))
						0: ready_mask = '1;
						1: ready_mask = 16'($urandom);
						2: ready_mask = 16'($urandom | $urandom);
						default: ready_mask = 16'($urandom & $urandom);
					endcase
					// Keep bit 0 of the 16-bit mask set to bound the stall.
					ready_mask[0] = 1'b1;
				end
				out_ch.ready <= ready_mask[rx_cycle[3:0]];
				rx_cycle++;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
